// File: src/wrtl_pkg.sv
// ----------------------------------------------------------------------------
// wrtl_pkg: shared definitions for the weighted route table lookup
// Item opcodes, configuration register indexes, LFSR constants and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wrtl_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_WR_ROUTE  = 2'd0;
  localparam logic [1:0] OP_WR_WEIGHT = 2'd1;
  localparam logic [1:0] OP_LOOKUP    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINKS   = 2'd0;
  localparam logic [1:0] CFG_ORDERED = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int LINKS_W    = 5;
  localparam int ORDERED_W  = 4;

  // Field widths of the transactions.
  localparam int OPCODE_W = 2;
  localparam int VNET_W   = 2;
  localparam int LINK_W   = 4;
  localparam int MASK_W   = 64;
  localparam int WEIGHT_W = 8;

  // Galois LFSR shifting right, polynomial x^16 + x^14 + x^13 + x^11 + 1.
  localparam int              LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'h0001;
  localparam int              DIV_CNT_W  = $clog2(LFSR_W);

  typedef struct packed {
    logic clr_step;
    logic load;
    logic scan_step;
    logic pick_first;
    logic lfsr_step;
    logic div_start;
    logic div_step;
    logic sel_step;
    logic res_load;
  } wrtl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_lookup;
    logic scan_none;
    logic scan_last;
    logic found;
    logic ordered;
    logic count_one;
    logic div_last;
    logic sel_hit;
  } wrtl_status_t;

endpackage

// File: src/wrtl_ctrl.sv
// ----------------------------------------------------------------------------
// wrtl_ctrl: sequencing controller
// Clears the tables after reset, then steps each lookup through the link
// scan, the tie-break division, the tie selection and the result handover.
// ----------------------------------------------------------------------------
module wrtl_ctrl
  import wrtl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  wrtl_status_t status,
  output wrtl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_DIV,
    S_SEL,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_lookup) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (status.scan_none) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
          if (status.scan_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status.found) begin
          state_nxt = S_RESULT;
        end else if (status.ordered) begin
          cmd.pick_first = 1'b1;
          state_nxt      = S_RESULT;
        end else begin
          // The LFSR steps on every unordered lookup that finds a candidate.
          cmd.lfsr_step = 1'b1;
          if (status.count_one) begin
            cmd.pick_first = 1'b1;
            state_nxt      = S_RESULT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        if (status.sel_hit) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/wrtl_dp.sv
// ----------------------------------------------------------------------------
// wrtl_dp: table storage and lookup datapath
// Holds the route and weight memories, the configuration registers, the
// running minimum over the scanned links, the tie LFSR with its restoring
// divider, the tie selector and the result register.
// ----------------------------------------------------------------------------
module wrtl_dp
  import wrtl_pkg::*;
#(
  parameter int NUM_VNETS = 4,
  parameter int NUM_LINKS = 16,
  parameter int DEST_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [VNET_W-1:0]     in_vnet,
  input  logic [LINK_W-1:0]     in_link,
  input  logic [MASK_W-1:0]     in_dest_mask,
  input  logic [WEIGHT_W-1:0]   in_weight,
  input  wrtl_cmd_t             cmd,
  output wrtl_status_t          status,
  output logic [LINK_W-1:0]     out_link,
  output logic                  out_no_route
);

  localparam int RT_DEPTH = NUM_VNETS * NUM_LINKS;
  localparam int RT_AW    = (RT_DEPTH > 1) ? $clog2(RT_DEPTH) : 1;
  localparam int LINK_AW  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int CNT_W    = $clog2(NUM_LINKS + 1);

  // Configuration registers.
  logic [LINKS_W-1:0]   cfg_links_r;
  logic [ORDERED_W-1:0] cfg_ordered_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_links_r   <= '0;
      cfg_ordered_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINKS:   cfg_links_r   <= cfg_wdata[LINKS_W-1:0];
        CFG_ORDERED: cfg_ordered_r <= cfg_wdata[ORDERED_W-1:0];
        default:     ;
      endcase
    end
  end

  // Clearing sweep after reset.
  logic [RT_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + RT_AW'(1);
    end
  end

  assign status.clr_last = (32'(clr_cnt_r) == RT_DEPTH - 1);

  // Lookup transaction registers.
  logic [VNET_W-1:0]    vnet_r;
  logic [DEST_BITS-1:0] dmask_r;
  logic                 vnet_ok_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     scan_cnt_r;
  logic [CNT_W-1:0]     n_nxt;

  assign n_nxt = (32'(cfg_links_r) > NUM_LINKS) ? CNT_W'(NUM_LINKS) : CNT_W'(cfg_links_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vnet_r     <= in_vnet;
      dmask_r    <= in_dest_mask[DEST_BITS-1:0];
      vnet_ok_r  <= (32'(in_vnet) < NUM_VNETS);
      n_r        <= n_nxt;
      scan_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
    end
  end

  assign status.in_lookup = (in_opcode == OP_LOOKUP);
  assign status.scan_none = !vnet_ok_r || (n_r == '0);
  assign status.scan_last = (32'(scan_cnt_r) + 1 == 32'(n_r));
  assign status.ordered   = cfg_ordered_r[vnet_r];

  // Route mask memory: one write port, one registered read port.
  logic [DEST_BITS-1:0] rt_mem [RT_DEPTH];
  logic [DEST_BITS-1:0] rt_rd_r;
  logic                 rt_we;
  logic [RT_AW-1:0]     rt_waddr;
  logic [DEST_BITS-1:0] rt_wdata;
  logic [RT_AW-1:0]     rt_raddr;

  always_comb begin
    if (cmd.clr_step) begin
      rt_we    = 1'b1;
      rt_waddr = clr_cnt_r;
      rt_wdata = '0;
    end else begin
      rt_we    = cmd.load && (in_opcode == OP_WR_ROUTE) &&
                 (32'(in_vnet) < NUM_VNETS) && (32'(in_link) < NUM_LINKS);
      rt_waddr = RT_AW'(in_vnet) * RT_AW'(NUM_LINKS) + RT_AW'(in_link);
      rt_wdata = in_dest_mask[DEST_BITS-1:0];
    end
  end

  assign rt_raddr = RT_AW'(vnet_r) * RT_AW'(NUM_LINKS) + RT_AW'(scan_cnt_r[LINK_AW-1:0]);

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_waddr] <= rt_wdata;
    end
    rt_rd_r <= rt_mem[rt_raddr];
  end

  // Link weight memory.
  logic [WEIGHT_W-1:0] wt_mem [NUM_LINKS];
  logic [WEIGHT_W-1:0] wt_rd_r;
  logic                wt_we;
  logic [LINK_AW-1:0]  wt_waddr;
  logic [WEIGHT_W-1:0] wt_wdata;

  always_comb begin
    if (cmd.clr_step) begin
      wt_we    = (32'(clr_cnt_r) < NUM_LINKS);
      wt_waddr = LINK_AW'(clr_cnt_r);
      wt_wdata = '0;
    end else begin
      wt_we    = cmd.load && (in_opcode == OP_WR_WEIGHT) && (32'(in_link) < NUM_LINKS);
      wt_waddr = LINK_AW'(in_link);
      wt_wdata = in_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_rd_r <= wt_mem[scan_cnt_r[LINK_AW-1:0]];
  end

  // Read data arrives in the cycle after the address is issued.
  logic               rd_valid_r;
  logic [LINK_AW-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_idx_r <= scan_cnt_r[LINK_AW-1:0];
    end
  end

  // Running minimum, first link at the minimum, tie count and tie flags.
  logic                 min_valid_r;
  logic [WEIGHT_W-1:0]  min_w_r;
  logic [LINK_AW-1:0]   first_link_r;
  logic [CNT_W-1:0]     count_r;
  logic [NUM_LINKS-1:0] flags_r;
  logic                 cand;
  logic                 take_new;
  logic                 take_tie;

  assign cand     = rd_valid_r && (|(rt_rd_r & dmask_r));
  assign take_new = cand && (!min_valid_r || (wt_rd_r < min_w_r));
  assign take_tie = cand && min_valid_r && (wt_rd_r == min_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_valid_r <= 1'b0;
    end else if (cmd.load) begin
      min_valid_r <= 1'b0;
    end else if (take_new) begin
      min_valid_r <= 1'b1;
    end
  end

  // Divider and selector state.
  logic [LFSR_W-1:0]    lfsr_r;
  logic [LFSR_W-1:0]    lfsr_nxt;
  logic [LFSR_W-1:0]    q_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     rem_nxt;
  logic [CNT_W:0]       trial;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [LINK_AW-1:0]   sel_idx_r;
  logic [LINK_AW-1:0]   chosen_r;

  always_ff @(posedge clk) begin
    if (take_new) begin
      min_w_r      <= wt_rd_r;
      first_link_r <= rd_idx_r;
      count_r      <= CNT_W'(1);
      flags_r      <= NUM_LINKS'(1) << rd_idx_r;
    end else if (take_tie) begin
      count_r           <= count_r + CNT_W'(1);
      flags_r[rd_idx_r] <= 1'b1;
    end else if (cmd.sel_step) begin
      flags_r <= flags_r >> 1;
    end
  end

  assign status.found     = min_valid_r;
  assign status.count_one = (count_r == CNT_W'(1));

  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (cmd.lfsr_step) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // Restoring division, one quotient bit a cycle; only the remainder is kept.
  assign trial   = {rem_r, q_r[LFSR_W-1]};
  assign rem_nxt = (trial >= {1'b0, count_r}) ? CNT_W'(trial - {1'b0, count_r})
                                              : trial[CNT_W-1:0];

  assign status.div_last = (div_cnt_r == DIV_CNT_W'(LFSR_W - 1));
  assign status.sel_hit  = flags_r[0] && (rem_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r       <= lfsr_nxt;
      rem_r     <= '0;
      div_cnt_r <= '0;
      sel_idx_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= q_r << 1;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end else if (cmd.sel_step) begin
      // The remainder counts down the tied links still to be skipped.
      sel_idx_r <= sel_idx_r + LINK_AW'(1);
      if (flags_r[0] && (rem_r != '0)) begin
        rem_r <= rem_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_first) begin
      chosen_r <= first_link_r;
    end else if (cmd.sel_step && status.sel_hit) begin
      chosen_r <= sel_idx_r;
    end
  end

  // Result register.
  logic [LINK_W-1:0] out_link_r;
  logic              out_no_route_r;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_link_r     <= min_valid_r ? LINK_W'(chosen_r) : '0;
      out_no_route_r <= !min_valid_r;
    end
  end

  assign out_link     = out_link_r;
  assign out_no_route = out_no_route_r;

endmodule

// File: src/weighted_route_table_lookup.sv
// ----------------------------------------------------------------------------
// weighted_route_table_lookup: minimum-weight route table lookup
// Route mask and link weight tables with a lookup that picks the lightest
// link reaching any requested destination.
// ----------------------------------------------------------------------------
// Usage: the input channel carries transactions that write a route mask,
// write a link weight or request a lookup. Writes complete in the cycle they
// are accepted and produce no result. A lookup produces one result on the
// output channel: the chosen link, or the no-route flag with link zero.
// A lookup scans the n links searched, reading one route mask and one
// weight a cycle from the tables. With several tied candidates on an
// unordered virtual network it then adds a remainder division and a tie
// selection. Input is taken again once the lookup has handed its result
// to the output register.
// After reset both tables are swept to zero, one route entry a cycle over all
// NUM_VNETS * NUM_LINKS entries, with in_ready low; configuration writes are
// taken throughout. A stalled receiver holds the result in the output
// register; further writes are still accepted, and a following lookup waits
// at its end until the register is free.
// ----------------------------------------------------------------------------
module weighted_route_table_lookup
  import wrtl_pkg::*;
#(
  parameter int NUM_VNETS = 4,
  parameter int NUM_LINKS = 16,
  parameter int DEST_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [VNET_W-1:0]     in_vnet,
  input  logic [LINK_W-1:0]     in_link,
  input  logic [MASK_W-1:0]     in_dest_mask,
  input  logic [WEIGHT_W-1:0]   in_weight,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LINK_W-1:0]     out_link,
  output logic                  out_no_route
);

  wrtl_cmd_t    cmd;
  wrtl_status_t status;

  wrtl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wrtl_dp #(
    .NUM_VNETS (NUM_VNETS),
    .NUM_LINKS (NUM_LINKS),
    .DEST_BITS (DEST_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_opcode    (in_opcode),
    .in_vnet      (in_vnet),
    .in_link      (in_link),
    .in_dest_mask (in_dest_mask),
    .in_weight    (in_weight),
    .cmd          (cmd),
    .status       (status),
    .out_link     (out_link),
    .out_no_route (out_no_route)
  );

endmodule

// File: src/wrtl_chk.sv
// ----------------------------------------------------------------------------
// wrtl_chk: port-level checks for the route table lookup
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module wrtl_chk
  import wrtl_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OPCODE_W-1:0] in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LINK_W-1:0]   out_link,
  input logic                out_no_route
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_link) && $stable(out_no_route))
    else $error("result changed while stalled");

  // A lookup without a route reports link zero.
  a_no_route_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_route |-> out_link == '0)
    else $error("no-route result with a non-zero link");

  // The tables are swept after reset before any transaction is taken.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  // An accepted lookup occupies the block for at least the following cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_LOOKUP) |=> !in_ready)
    else $error("input ready in the cycle after a lookup");

endmodule

bind weighted_route_table_lookup wrtl_chk u_wrtl_chk (.*);

// File: tb/weighted_route_table_lookup_test.sv
// ----------------------------------------------------------------------------
// weighted_route_table_lookup_test: self-checking bench for the route lookup
// A queue-fed driver sends route writes, weight writes, lookups and unused
// opcodes. A clocked monitor mirrors the tables, the configuration and the
// tie LFSR, predicts every lookup result and checks each one in order.
// ----------------------------------------------------------------------------
module weighted_route_table_lookup_test;
  import wrtl_pkg::*;

  localparam int                   LINK_COUNT     = 16;
  localparam int                   VNET_COUNT     = 4;
  localparam int                   SETTLE_CYCLES  = 60;
  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam logic [OPCODE_W-1:0]  OP_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd2;
  localparam logic [MASK_W-1:0]    ALL_DEST       = {MASK_W{1'b1}};

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VNET_W-1:0]   vnet;
    logic [LINK_W-1:0]   link;
    logic [MASK_W-1:0]   dest_mask;
    logic [WEIGHT_W-1:0] weight;
  } route_item_t;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              no_route;
  } route_result_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   in_opcode    = '0;
  logic [VNET_W-1:0]     in_vnet      = '0;
  logic [LINK_W-1:0]     in_link      = '0;
  logic [MASK_W-1:0]     in_dest_mask = '0;
  logic [WEIGHT_W-1:0]   in_weight    = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [LINK_W-1:0]     out_link;
  logic                  out_no_route;

  // Mirror of the block's state.
  logic [MASK_W-1:0]   route_tbl [VNET_COUNT][LINK_COUNT];
  logic [WEIGHT_W-1:0] weight_tbl [LINK_COUNT];
  logic [LFSR_W-1:0]   tie_lfsr = LFSR_SEED;
  logic [LINKS_W-1:0]  links_cfg = '0;
  logic [ORDERED_W-1:0] ordered_cfg = '0;

  route_item_t   pending_items [$];
  route_result_t route_results [$];
  logic          in_taken   = 1'b0;
  logic          quiet      = 1'b0;
  int            send_gap   = 0;
  int            recv_gap   = 0;
  int            mismatches = 0;
  int            idle_cycles = 0;

  weighted_route_table_lookup u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_vnet     (in_vnet),
    .in_link     (in_link),
    .in_dest_mask(in_dest_mask),
    .in_weight   (in_weight),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_link    (out_link),
    .out_no_route(out_no_route)
  );

  always #10 clk = ~clk;

  initial begin
    for (int v = 0; v < VNET_COUNT; v++) begin
      for (int l = 0; l < LINK_COUNT; l++) begin
        route_tbl[v][l] = '0;
      end
    end
    for (int l = 0; l < LINK_COUNT; l++) begin
      weight_tbl[l] = '0;
    end
  end

  // Appends one transaction to the tail of the driver's queue.
  task automatic queue_item(input route_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Applies one accepted transaction to the mirror and, for a lookup, works
  // out the link the block must choose.
  task automatic predict_transaction(input route_item_t it);
    int            searched;
    int            lowest_w;
    int            ties;
    int            pick;
    int            seen;
    logic          hit;
    logic          candidate;
    route_result_t res;
    case (it.opcode)
      OP_WR_ROUTE:  route_tbl[it.vnet][it.link] = it.dest_mask;
      OP_WR_WEIGHT: weight_tbl[it.link] = it.weight;
      OP_LOOKUP: begin
        searched = (links_cfg > LINK_COUNT) ? LINK_COUNT : int'(links_cfg);
        lowest_w = 256;
        for (int l = 0; l < searched; l++) begin
          candidate = (route_tbl[it.vnet][l] & it.dest_mask) != '0;
          if (candidate && weight_tbl[l] < lowest_w) lowest_w = weight_tbl[l];
        end
        res.link = '0;
        res.no_route = 1'b1;
        if (lowest_w != 256) begin
          ties = 0;
          for (int l = 0; l < searched; l++) begin
            candidate = (route_tbl[it.vnet][l] & it.dest_mask) != '0;
            if (candidate && weight_tbl[l] == lowest_w) ties++;
          end
          pick = 0;
          // Unordered networks step the LFSR even with a single candidate.
          if (!ordered_cfg[it.vnet]) begin
            tie_lfsr = {1'b0, tie_lfsr[LFSR_W-1:1]} ^ (tie_lfsr[0] ? LFSR_TAPS : '0);
            pick = int'(tie_lfsr) % ties;
          end
          seen = 0;
          hit = 1'b0;
          for (int l = 0; l < searched; l++) begin
            candidate = (route_tbl[it.vnet][l] & it.dest_mask) != '0;
            if (candidate && weight_tbl[l] == lowest_w && !hit) begin
              if (seen == pick) begin
                res.link = l[LINK_W-1:0];
                hit = 1'b1;
              end else begin
                seen++;
              end
            end
          end
          res.no_route = 1'b0;
        end
        route_results.insert(route_results.size(), res);
      end
      default: ;
    endcase
  endtask

  function automatic route_item_t make_item(input logic [OPCODE_W-1:0] op,
                                            input logic [VNET_W-1:0] vnet,
                                            input logic [LINK_W-1:0] link,
                                            input logic [MASK_W-1:0] mask,
                                            input logic [WEIGHT_W-1:0] weight);
    route_item_t it;
    it.opcode = op;
    it.vnet = vnet;
    it.link = link;
    it.dest_mask = mask;
    it.weight = weight;
    return it;
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 5))
      0:       m = '0;
      1:       m = ALL_DEST;
      2:       m = 64'd1 << $urandom_range(0, MASK_W - 1);
      3:       m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: m = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  // Mostly well-formed traffic; a few weights cover the full range, most are
  // small so that ties are common.
  task automatic queue_random(input int count);
    int                  r;
    logic [WEIGHT_W-1:0] w;
    route_item_t         it;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      w = ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 255))
                                      : WEIGHT_W'($urandom_range(0, 2));
      it = make_item(OP_LOOKUP, VNET_W'($urandom_range(0, 3)), LINK_W'($urandom_range(0, 15)),
                     random_mask(), WEIGHT_W'($urandom_range(0, 255)));
      if (r < 30) begin
        it.opcode = OP_WR_ROUTE;
      end else if (r < 50) begin
        it.opcode = OP_WR_WEIGHT;
        it.weight = w;
      end else if (r >= 95) begin
        it.opcode = OP_UNUSED;
        it.dest_mask = {$urandom, $urandom};
      end
      queue_item(it);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LINKS:   links_cfg = val;
      CFG_ORDERED: ordered_cfg = val[ORDERED_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every transaction is accepted and every result has arrived,
  // then lets the block settle.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || route_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: a new transaction is presented only once the previous one has
  // gone, so valid never drops before acceptance.
  always @(negedge clk) begin
    route_item_t nxt;
    logic        load;
    if (rst_n) begin
      load = 1'b0;
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(0, 2);
          else load = 1'b1;
        end
        if (load) begin
          nxt = pending_items.pop_front();
          in_opcode <= nxt.opcode;
          in_vnet <= nxt.vnet;
          in_link <= nxt.link;
          in_dest_mask <= nxt.dest_mask;
          in_weight <= nxt.weight;
        end
        in_valid <= load;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    route_item_t   seen_item;
    route_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen_item = make_item(in_opcode, in_vnet, in_link, in_dest_mask, in_weight);
        predict_transaction(seen_item);
      end
      if (out_valid && out_ready) begin
        if (route_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual link %0d no_route %0b",
                   $time, out_link, out_no_route);
          mismatches++;
        end else begin
          want = route_results.pop_front();
          if (out_link !== want.link) begin
            $display("%0t: out_link mismatch: expected %0d, actual %0d",
                     $time, want.link, out_link);
            mismatches++;
          end
          if (out_no_route !== want.no_route) begin
            $display("%0t: out_no_route mismatch: expected %0b, actual %0b",
                     $time, want.no_route, out_no_route);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                  phase_links [6];
    int                  phase_ordered [6];
    int                  phase_items [6];
    phase_links   = '{0, 31, 1, 17, 0, 16};
    phase_ordered = '{15, 26, 0, 3, 0, 0};
    phase_items   = '{60, 190, 190, 190, 190, 180};
    phase_links[4]   = $urandom_range(2, 15);
    phase_ordered[4] = $urandom_range(0, 31);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ordered networks 0 and 2, unordered 1 and 3.
    write_register(CFG_LINKS, 5'd16);
    write_register(CFG_ORDERED, 5'b00101);

    // Lookup on empty tables finds nothing.
    queue_item(make_item(OP_LOOKUP, 2'd0, 4'd0, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd0, 4'd0, 64'd1, 8'hFF));
    queue_item(make_item(OP_WR_ROUTE, 2'd0, 4'd15, 64'h8000_0000_0000_0000, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd3, 4'd15, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd1, 4'd3, 64'h0000_FFFF_0000_0000, 8'd0));
    queue_item(make_item(OP_WR_WEIGHT, 2'd3, 4'd0, ALL_DEST, 8'd255));
    queue_item(make_item(OP_WR_WEIGHT, 2'd0, 4'd15, 64'd0, 8'd0));
    queue_item(make_item(OP_WR_WEIGHT, 2'd0, 4'd3, 64'd0, 8'd0));
    queue_item(make_item(OP_LOOKUP, 2'd0, 4'd0, ALL_DEST, 8'd0));
    queue_item(make_item(OP_LOOKUP, 2'd0, 4'd15, 64'd1, 8'hFF));
    queue_item(make_item(OP_LOOKUP, 2'd0, 4'd0, 64'd0, 8'd0));
    queue_item(make_item(OP_UNUSED, 2'd3, 4'd15, ALL_DEST, 8'hFF));
    // Single candidate on an unordered network still steps the LFSR.
    queue_item(make_item(OP_LOOKUP, 2'd3, 4'd0, 64'd1, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd1, 4'd7, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_WEIGHT, 2'd1, 4'd7, 64'd0, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd1, 4'd9, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_WEIGHT, 2'd1, 4'd9, 64'd0, 8'd0));
    // Three-way tie on an unordered network.
    queue_item(make_item(OP_LOOKUP, 2'd1, 4'd0, 64'h0000_0001_0000_0000, 8'd0));
    queue_item(make_item(OP_LOOKUP, 2'd1, 4'd0, 64'h0000_8000_0000_0000, 8'd0));
    queue_item(make_item(OP_LOOKUP, 2'd1, 4'd0, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd2, 4'd1, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd2, 4'd2, ALL_DEST, 8'd0));
    queue_item(make_item(OP_WR_ROUTE, 2'd2, 4'd14, 64'h00F0_0000_0000_0000, 8'd0));
    // Tie on an ordered network goes to the lowest link.
    queue_item(make_item(OP_LOOKUP, 2'd2, 4'd0, ALL_DEST, 8'd0));
    queue_item(make_item(OP_LOOKUP, 2'd2, 4'd0, 64'h0010_0000_0000_0000, 8'd0));

    for (int p = 0; p < 6; p++) begin
      drain();
      write_register(CFG_LINKS, CFG_DATA_W'(phase_links[p]));
      write_register(CFG_ORDERED, CFG_DATA_W'(phase_ordered[p]));
      // The spare index must leave both registers alone.
      if (p == 1) write_register(CFG_SPARE, 5'h1F);
      if (p == 5) quiet = 1'b1;
      queue_random(phase_items[p]);
    end
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
